### rtl/kvt_pkg.sv
// shared types and codes for the key/value table
package kvt_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } kvt_state_t;

endpackage

### rtl/kvt_ram.sv
// generic single-write, single-read ram with registered read data
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/key_value_table_core.sv
// top level of the bounded associative key/value table
//
// Each item is a put or a get on a table of up to TABLE_DEPTH signed 32-bit
// keys and values. Valid slots are packed from slot 0 up to the entry count
// and are searched one slot per cycle through the single read port of the
// key and value memories. An empty table skips the search; a hit ends it at
// the matching slot and a miss searches every valid slot. The next item can
// be accepted in the cycle after the result is loaded. The block takes one
// item at a time; a finished result waits in the output register and the
// next item may be accepted meanwhile. Reset empties the table at once,
// with no clearing pass.
module key_value_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic signed [kvt_pkg::KEY_W-1:0]   req_key,
  input  logic signed [kvt_pkg::VALUE_W-1:0] req_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [kvt_pkg::VALUE_W-1:0] read_value,
  output logic                        hit,
  output logic                        table_full,
  output logic [kvt_pkg::COUNT_W-1:0] entry_count
);

  import kvt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  kvt_state_t state, state_next;

  logic               type_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;

  logic [IW-1:0] issue_idx;
  logic [IW-1:0] cmp_idx;
  logic          cmp_valid;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic               found;
  logic [IW-1:0]      found_idx;
  logic [VALUE_W-1:0] found_val;

  logic [KEY_W-1:0]   key_rd;
  logic [VALUE_W-1:0] val_rd;

  logic          key_we;
  logic          val_we;
  logic [IW-1:0] wr_addr;

  logic in_fire;
  logic out_free;
  logic key_match;
  logic cmp_last;
  logic finish_go;
  logic drop_full;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign key_match = cmp_valid && (key_rd == key_r);
  assign cmp_last  = cmp_valid && (CW'(cmp_idx) == count - CW'(1));
  assign finish_go = (state == ST_FINISH) && out_free;

  always_comb begin
    state_next = state;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_addr    = found_idx;
    count_next = count;
    drop_full  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (count == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (key_match || cmp_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (type_r == REQ_PUT) begin
          if (found) begin
            val_we = 1'b1;
          end else if (count < DEPTH_C) begin
            // append a new entry right after the last valid slot
            key_we     = 1'b1;
            val_we     = 1'b1;
            wr_addr    = count[IW-1:0];
            count_next = count + CW'(1);
          end else begin
            drop_full = 1'b1;
          end
        end
        if (!out_free) begin
          key_we     = 1'b0;
          val_we     = 1'b0;
          count_next = count;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        cmp_valid <= 1'b0;
      end else if (state == ST_SEARCH) begin
        cmp_valid <= 1'b1;
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      type_r    <= req_type;
      key_r     <= req_key;
      value_r   <= req_value;
      issue_idx <= '0;
      found     <= 1'b0;
    end else if (state == ST_SEARCH) begin
      issue_idx <= issue_idx + IW'(1);
      cmp_idx   <= issue_idx;
      if (key_match || cmp_last) begin
        found     <= key_match;
        found_idx <= cmp_idx;
        found_val <= val_rd;
      end
    end
    if (finish_go) begin
      read_value  <= (type_r == REQ_GET && found) ? found_val : '0;
      hit         <= found;
      table_full  <= drop_full;
      entry_count <= COUNT_W'(count_next);
    end
  end

  kvt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (wr_addr),
    .wr_data (key_r),
    .rd_addr (issue_idx),
    .rd_data (key_rd)
  );

  kvt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_addr (issue_idx),
    .rd_data (val_rd)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_hit_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && table_full))
    else $error("item reported both hit and full");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    finish_go && drop_full |-> count == DEPTH_C)
    else $error("put dropped while table had room");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish step");

endmodule

### test/key_value_table_core_test.sv
// self-checking testbench for key_value_table_core: directed rows, then random puts and gets
module key_value_table_core_test;
  import kvt_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 630;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic found;
    logic dropped;
    logic [COUNT_W-1:0] count;
  } lookup_result_t;

  typedef struct packed {
    logic op;
    logic [KEY_W-1:0] key;
    logic [VALUE_W-1:0] val;
    logic typed;
    lookup_result_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 18;
  // rows with typed = 1 carry the result they must produce
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 7'd0}},
    '{REQ_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 7'd1}},
    '{REQ_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 7'd2}},
    '{REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b0, 7'd2}},
    '{REQ_GET, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 7'd2}},
    '{REQ_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 7'd2}},
    // hit on a stored zero must still report found
    '{REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 7'd2}},
    '{REQ_PUT, 32'h0000_0000, 32'hffff_ffff, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 7'd3}},
    '{REQ_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 7'd3}},
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1, 1'b0, 7'd3}},
    '{REQ_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 7'd3}},
    '{REQ_PUT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0},
    '{REQ_PUT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0},
    '{REQ_GET, 32'haaaa_aaaa, 32'h1234_5678, 1'b0, '0},
    '{REQ_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, '0},
    '{REQ_PUT, 32'hffff_ffff, 32'h0000_0001, 1'b0, '0},
    '{REQ_GET, 32'h7fff_ffff, 32'hdead_beef, 1'b0, '0},
    '{REQ_PUT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_PUT;
  logic signed [KEY_W-1:0] req_key = '0;
  logic signed [VALUE_W-1:0] req_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_W-1:0] read_value;
  logic hit;
  logic table_full;
  logic [COUNT_W-1:0] entry_count;

  key_value_table_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .req_key(req_key),
    .req_value(req_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .hit(hit),
    .table_full(table_full),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [VALUE_W-1:0] shadow_vals [DEPTH];
  int shadow_count = 0;

  lookup_result_t pending_results [$];
  int error_count = 0;

  function automatic lookup_result_t lookup_and_update(logic op, logic [KEY_W-1:0] key,
                                                       logic [VALUE_W-1:0] val);
    lookup_result_t res;
    int slot;
    res = '0;
    slot = -1;
    for (int i = 0; i < shadow_count; i++)
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    res.found = (slot >= 0);
    if (op == REQ_GET) begin
      if (slot >= 0) res.value = shadow_vals[slot];
    end else if (slot >= 0) begin
      shadow_vals[slot] = val;
    end else if (shadow_count < DEPTH) begin
      shadow_keys[shadow_count] = key;
      shadow_vals[shadow_count] = val;
      shadow_count++;
    end else begin
      res.dropped = 1'b1;
    end
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  task automatic send_request(input stim_row_t row);
    lookup_result_t predicted;
    in_valid <= 1'b1;
    req_type <= row.op;
    req_key <= row.key;
    req_value <= row.val;
    do @(posedge clk); while (in_stall);
    predicted = lookup_and_update(row.op, row.key, row.val);
    if (row.typed) predicted = row.want;
    pending_results.push_back(predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern: modes of random length
  int stall_mode = 0;
  int stall_left = 0;
  logic [3:0] stall_phase = '0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 4'd1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_phase < 4'd10);
    endcase
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected item: read_value %h hit %b table_full %b entry_count %0d",
                 $time, read_value, hit, table_full, entry_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.value) begin
          $display("%0t read_value expected %h got %h", $time, want.value, read_value);
          error_count++;
        end
        if (hit !== want.found) begin
          $display("%0t hit expected %b got %b", $time, want.found, hit);
          error_count++;
        end
        if (table_full !== want.dropped) begin
          $display("%0t table_full expected %b got %b", $time, want.dropped, table_full);
          error_count++;
        end
        if (entry_count !== want.count) begin
          $display("%0t entry_count expected %0d got %0d", $time, want.count, entry_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int burst_left;
    int gap;
    int pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_request(DIRECTED_ROWS[i]);
    drain_results();

    // mostly known keys, so updates and hits are common; new keys fill the table,
    // after which puts of new keys must be dropped
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row = '0;
      row.op = 1'($urandom_range(0, 1));
      row.val = $urandom;
      pick = $urandom_range(0, 9);
      if (shadow_count != 0 && pick < 6)
        row.key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else if (pick < 8)
        row.key = $urandom;
      else
        row.key = KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
      send_request(row);
      if (n % 150 == 149) begin
        drain_results();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/kvt_pkg.sv
rtl/kvt_ram.sv
rtl/key_value_table_core.sv
test/key_value_table_core_test.sv
